>>> rtl/lr_pkg.sv
package lr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int COLOR_BITS  = 16;
  localparam int SPAN_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [SPAN_BITS-1:0]  span_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } in_word_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } out_word_t;

  typedef struct packed {
    kind_t  kind;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    color_t color;
    logic   x_neg;
    logic   y_neg;
    logic   x_major;
    span_t  twice_major;
    span_t  twice_minor;
    err_t   err;
  } cmd_t;

  function automatic coord_t move_one(coord_t v, logic neg);
    return neg ? (v - coord_t'(1)) : (v + coord_t'(1));
  endfunction

endpackage

>>> rtl/lr_front.sv
module lr_front import lr_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     q_valid,
  input  logic     q_ready,
  output cmd_t     q_cmd
);

  coord_t dx, dy, dmaj, dmin;
  logic   x_neg, y_neg, x_major;
  span_t  tmaj, tmin;

  always_comb begin
    x_neg   = in_word.end_x < in_word.start_x;
    y_neg   = in_word.end_y < in_word.start_y;
    dx      = x_neg ? (in_word.start_x - in_word.end_x) : (in_word.end_x - in_word.start_x);
    dy      = y_neg ? (in_word.start_y - in_word.end_y) : (in_word.end_y - in_word.start_y);
    x_major = dx >= dy;
    dmaj    = x_major ? dx : dy;
    dmin    = x_major ? dy : dx;
    tmaj    = {dmaj, 1'b0};
    tmin    = {dmin, 1'b0};

    q_cmd.kind        = in_word.kind;
    q_cmd.sx          = in_word.start_x;
    q_cmd.sy          = in_word.start_y;
    q_cmd.ex          = in_word.end_x;
    q_cmd.ey          = in_word.end_y;
    q_cmd.color       = in_word.line_color;
    q_cmd.x_neg       = x_neg;
    q_cmd.y_neg       = y_neg;
    q_cmd.x_major     = x_major;
    q_cmd.twice_major = tmaj;
    q_cmd.twice_minor = tmin;
    q_cmd.err         = $signed({2'b00, tmin}) - $signed({3'b000, dmaj});
  end

  assign q_valid  = in_valid;
  assign in_ready = q_ready;

endmodule

>>> rtl/lr_queue.sv
module lr_queue import lr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push, pop;

  assign wr_ready = count != QCNT_BITS'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_cmd   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [QPTR_BITS-1:0] bump(logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/lr_back.sv
module lr_back import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic   active;
  coord_t cur_x, cur_y, target_x, target_y;
  logic   step_x_neg, step_y_neg, x_major;
  err_t   error_term;
  span_t  twice_major, twice_minor;
  color_t held_color;

  coord_t adv_x, adv_y;
  err_t   adv_err;
  logic   adv_last, start_last;

  assign q_ready = !out_valid || out_ready;

  always_comb begin
    adv_x   = cur_x;
    adv_y   = cur_y;
    adv_err = error_term + $signed({2'b00, twice_minor});
    if (!error_term[ERR_BITS-1]) begin
      adv_err = adv_err - $signed({2'b00, twice_major});
      if (x_major) begin
        adv_y = move_one(cur_y, step_y_neg);
      end else begin
        adv_x = move_one(cur_x, step_x_neg);
      end
    end
    if (x_major) begin
      adv_x = move_one(cur_x, step_x_neg);
    end else begin
      adv_y = move_one(cur_y, step_y_neg);
    end
    adv_last   = x_major ? (adv_x == target_x) : (adv_y == target_y);
    start_last = q_cmd.x_major ? (q_cmd.sx == q_cmd.ex) : (q_cmd.sy == q_cmd.ey);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      active      <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      x_major     <= 1'b0;
      error_term  <= '0;
      twice_major <= '0;
      twice_minor <= '0;
      held_color  <= '0;
    end else begin
      if (q_valid && q_ready) begin
        out_valid <= 1'b1;
        unique case (q_cmd.kind)
          KIND_START: begin
            active               <= !start_last;
            cur_x                <= q_cmd.sx;
            cur_y                <= q_cmd.sy;
            target_x             <= q_cmd.ex;
            target_y             <= q_cmd.ey;
            step_x_neg           <= q_cmd.x_neg;
            step_y_neg           <= q_cmd.y_neg;
            x_major              <= q_cmd.x_major;
            error_term           <= q_cmd.err;
            twice_major          <= q_cmd.twice_major;
            twice_minor          <= q_cmd.twice_minor;
            held_color           <= q_cmd.color;
            out_word.pixel_valid <= 1'b1;
            out_word.pixel_x     <= q_cmd.sx;
            out_word.pixel_y     <= q_cmd.sy;
            out_word.pixel_color <= q_cmd.color;
            out_word.last_pixel  <= start_last;
          end
          KIND_ADVANCE: begin
            if (active) begin
              cur_x                <= adv_x;
              cur_y                <= adv_y;
              error_term           <= adv_err;
              active               <= !adv_last;
              out_word.pixel_valid <= 1'b1;
              out_word.pixel_x     <= adv_x;
              out_word.pixel_y     <= adv_y;
              out_word.pixel_color <= held_color;
              out_word.last_pixel  <= adv_last;
            end else begin
              out_word <= '0;
            end
          end
          default: begin
            out_word <= '0;
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/line_rasterizer_top.sv
// Bresenham line rasterizer. A start word latches both endpoints and a color and
// returns the first endpoint; each advance word returns the next pixel, with the
// final endpoint flagged last_pixel. An advance with no line active returns an
// all-zero word. Exactly one result word per input word, in order. Throughput is
// one word per clock while px_ready is high: the front computes spans and the
// initial error term, a two-entry queue decouples it from the stepper, whose
// single add/compare step per cycle sets the rate and registers each result.
module line_rasterizer_top import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_word_t  cmd,
  output logic      px_valid,
  input  logic      px_ready,
  output out_word_t px
);

  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  lr_front u_front (
    .in_valid (cmd_valid),
    .in_ready (cmd_ready),
    .in_word  (cmd),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_cmd    (fq_cmd)
  );

  lr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_cmd     (qb_cmd),
    .out_valid (px_valid),
    .out_ready (px_ready),
    .out_word  (px)
  );

endmodule
